/* src/vcd_pkg.sv */
// Package for the LFO modulated delay line: register indexes, fixed field widths,
// reset values, the sine lookup result type and the quarter-wave sine generator.
// No dependencies; the files that use it refer to it by scoped names.
package vcd_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register widths
    localparam int BASE_W  = 18;
    localparam int DEPTH_W = 18;
    localparam int INCR_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int PHASE_W = 32;

    // Sine magnitude (Q0.15, saturated at 32767) and signed tap delay width
    localparam int SINE_MAG_W = 15;
    localparam int DELAY_W    = 20;

    // Register reset values
    localparam logic [BASE_W-1:0]  BASE_RESET  = 18'd61440;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 18'd0;
    localparam logic [INCR_W-1:0]  INCR_RESET  = 32'd599506;
    localparam logic               CHORUS_RESET = 1'b0;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd32768;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_DELAY    = 3'd0,
        REG_DEPTH_DELAY   = 3'd1,
        REG_LFO_INCREMENT = 3'd2,
        REG_CHORUS_ON     = 3'd3,
        REG_OUTPUT_GAIN   = 3'd4
    } cfg_reg_t;

    // Sine lookup result, sign and magnitude
    typedef struct packed {
        logic                  neg;
        logic [SINE_MAG_W-1:0] mag;
    } sine_t;

    // Odd polynomial coefficients, Q30
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598673;
    localparam logic [63:0] SC5 = 64'd85569275;
    localparam logic [63:0] SC7 = 64'd5026931;
    localparam logic [63:0] SC9 = 64'd172271;

    // Quarter-wave sine magnitude for folded index j; t = j << shift is Q30.
    // Only evaluated on constants to build the lookup table.
    function automatic logic [SINE_MAG_W-1:0] sine_quarter(input int unsigned j,
                                                         input int unsigned shift);
        logic [63:0] t, t2, t3, t5, t7, t9;
        logic [63:0] pos, neg, v, m;
        t   = 64'(j) << shift;
        t2  = (t * t) >> 30;
        t3  = (t2 * t) >> 30;
        t5  = (t3 * t2) >> 30;
        t7  = (t5 * t2) >> 30;
        t9  = (t7 * t2) >> 30;
        pos = ((SC1 * t) >> 30) + ((SC5 * t5) >> 30) + ((SC9 * t9) >> 30);
        neg = ((SC3 * t3) >> 30) + ((SC7 * t7) >> 30);
        v   = (pos > neg) ? (pos - neg) : 64'd0;
        m   = (v + 64'd16384) >> 15;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return m[SINE_MAG_W-1:0];
    endfunction

endpackage

/* src/vibrato_chorus_delay.sv */
// Each accepted beat runs the sine lookup, the LFO swing, two delay memory reads,
// interpolation and output gain, with three 18-step passes through the shared
// bit-serial multiplier. No new beat is accepted until its result is handed on.
// Reset: synchronous, active low; control state and write pointer clear, registers
// take their defaults. No clearing pass: entries not yet written read as zero.
// Depends on vcd_pkg, vcd_ram, vcd_sine, vcd_sermul. Depths are powers of two.
module vibrato_chorus_delay #(
    parameter int DELAY_DEPTH      = 1024,
    parameter int SAMPLE_WIDTH     = 16,
    parameter int DELAY_FRAC_BITS  = 8,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input sample channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_dry_sample,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     m_out_sample,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [vcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int F   = DELAY_FRAC_BITS;
    localparam int L   = $clog2(SINE_TABLE_DEPTH);
    localparam int PW  = AW + F;
    localparam int XW  = ((PW > vcd_pkg::DELAY_W) ? PW : vcd_pkg::DELAY_W) + 1;
    localparam int MCW = ((SW + 1) > (vcd_pkg::SINE_MAG_W + 1)) ? (SW + 1)
                                                                : (vcd_pkg::SINE_MAG_W + 1);
    localparam int MW  = vcd_pkg::DEPTH_W;
    localparam int PRW = MCW + MW + 1;

    localparam logic signed [PRW-1:0] YMAX = {{(PRW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [PRW-1:0] YMIN = {{(PRW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINE,
        ST_SWING,
        ST_READ0,
        ST_READ1,
        ST_READ2,
        ST_INTERP,
        ST_GAIN_GO,
        ST_GAIN,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic [vcd_pkg::BASE_W-1:0]  base_reg;
    logic [vcd_pkg::DEPTH_W-1:0] depth_reg;
    logic [vcd_pkg::INCR_W-1:0]  incr_reg;
    logic                        chorus_reg;
    logic [vcd_pkg::GAIN_W-1:0]  gain_reg;

    // Sequencer state and datapath registers
    state_t                       state_reg, state_next;
    logic [AW-1:0]                wi_reg, wi_next;
    logic                         wrapped_reg, wrapped_next;
    logic [vcd_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic signed [SW-1:0]         dry_reg, dry_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic signed [SW-1:0]         s0_reg, s0_next;
    logic signed [SW-1:0]         post_reg, post_next;
    logic signed [SW-1:0]         y_reg, y_next;
    logic signed [SW-1:0]         out_reg, out_next;
    logic                         m_valid_reg, m_valid_next;

    // Submodule connections
    vcd_pkg::sine_t               sine_val;
    logic [SW-1:0]                rd_data;
    logic [AW-1:0]                rd_addr;
    logic                         mul_start;
    logic signed [MCW-1:0]        mul_mcand;
    logic [MW-1:0]                mul_mplier;
    logic                         mul_done;
    logic signed [PRW-1:0]        mul_product;

    // Combinational datapath
    logic                         accept;
    logic [AW-1:0]                i0, i1;
    logic [F-1:0]                 frac;
    logic                         valid0, valid1;
    logic [34:0]                  swing_rnd;
    logic signed [vcd_pkg::DELAY_W-1:0] swing_m;
    logic signed [vcd_pkg::DELAY_W-1:0] delay_s;
    logic [XW-1:0]                pos_diff;
    logic signed [SW-1:0]         s1_val;
    logic signed [SW:0]           tap_diff;
    logic signed [PRW-1:0]        interp_sum, interp_shift;
    logic signed [SW:0]           interp_t;
    logic signed [SW:0]           tap_w;
    logic signed [SW-1:0]         tap;
    logic signed [SW:0]           mix_sum;
    logic signed [SW-1:0]         post_val;
    logic signed [PRW-1:0]        gain_sum, gain_shift;
    logic signed [SW-1:0]         y_sat;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= vcd_pkg::BASE_RESET;
            depth_reg  <= vcd_pkg::DEPTH_RESET;
            incr_reg   <= vcd_pkg::INCR_RESET;
            chorus_reg <= vcd_pkg::CHORUS_RESET;
            gain_reg   <= vcd_pkg::GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                vcd_pkg::REG_BASE_DELAY:    base_reg   <= cfg_wdata[vcd_pkg::BASE_W-1:0];
                vcd_pkg::REG_DEPTH_DELAY:   depth_reg  <= cfg_wdata[vcd_pkg::DEPTH_W-1:0];
                vcd_pkg::REG_LFO_INCREMENT: incr_reg   <= cfg_wdata[vcd_pkg::INCR_W-1:0];
                vcd_pkg::REG_CHORUS_ON:     chorus_reg <= cfg_wdata[0];
                vcd_pkg::REG_OUTPUT_GAIN:   gain_reg   <= cfg_wdata[vcd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Delay memory; a write happens with each accepted beat
    assign rd_addr = (state_reg == ST_READ1) ? i1 : i0;

    vcd_ram #(
        .WIDTH (SW),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wi_reg),
        .wdata (s_dry_sample),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    vcd_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk      (aclk),
        .phase_idx (phase_reg[vcd_pkg::PHASE_W-1 -: L]),
        .sine      (sine_val)
    );

    vcd_sermul #(
        .MCAND_W  (MCW),
        .MPLIER_W (MW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    // Tap position split and fill tracking: an entry counts once written
    assign i0     = pos_reg[PW-1:F];
    assign i1     = i0 + 1'b1;
    assign frac   = pos_reg[F-1:0];
    assign valid0 = wrapped_reg || (i0 <= wi_reg);
    assign valid1 = wrapped_reg || (i1 <= wi_reg);

    // Swing rounded on magnitude, then signed delay and wrapped tap position
    assign swing_rnd = {1'b0, mul_product[33:0]} + 35'd16384;
    assign swing_m   = signed'(swing_rnd[34:15]);
    assign delay_s   = signed'({2'b00, base_reg}) + (sine_val.neg ? -swing_m : swing_m);
    assign pos_diff  = (XW'(wi_reg) << F) - XW'(delay_s);

    // Interpolation: s0 + round((s1 - s0) * frac / 2^F)
    assign s1_val       = valid1 ? signed'(rd_data) : '0;
    assign tap_diff     = (SW+1)'(s1_val) - (SW+1)'(s0_reg);
    assign interp_sum   = mul_product + PRW'(2 ** (F - 1));
    assign interp_shift = interp_sum >>> F;
    assign interp_t     = signed'(interp_shift[SW:0]);
    assign tap_w        = (SW+1)'(s0_reg) + interp_t;
    assign tap          = signed'(tap_w[SW-1:0]);

    // Dry/wet selection
    assign mix_sum = (SW+1)'(dry_reg) + (SW+1)'(tap);
    always_comb begin
        if (chorus_reg) begin
            post_val = signed'(mix_sum[SW:1]);
        end else if (depth_reg != '0) begin
            post_val = tap;
        end else begin
            post_val = dry_reg;
        end
    end

    // Gain rounding and saturation
    assign gain_sum   = mul_product + PRW'(16384);
    assign gain_shift = gain_sum >>> 15;
    always_comb begin
        if (gain_shift > YMAX) begin
            y_sat = signed'(YMAX[SW-1:0]);
        end else if (gain_shift < YMIN) begin
            y_sat = signed'(YMIN[SW-1:0]);
        end else begin
            y_sat = signed'(gain_shift[SW-1:0]);
        end
    end

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        wi_next      = wi_reg;
        wrapped_next = wrapped_reg;
        phase_next   = phase_reg;
        dry_next     = dry_reg;
        pos_next     = pos_reg;
        s0_next      = s0_reg;
        post_next    = post_reg;
        y_next       = y_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mul_start    = 1'b0;
        mul_mcand    = '0;
        mul_mplier   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dry_next   = s_dry_sample;
                    state_next = ST_SINE;
                end
            end
            ST_SINE: begin
                mul_start  = 1'b1;
                mul_mcand  = MCW'({1'b0, sine_val.mag});
                mul_mplier = depth_reg;
                state_next = ST_SWING;
            end
            ST_SWING: begin
                if (mul_done) begin
                    pos_next   = pos_diff[PW-1:0];
                    state_next = ST_READ0;
                end
            end
            ST_READ0: begin
                state_next = ST_READ1;
            end
            ST_READ1: begin
                s0_next    = valid0 ? signed'(rd_data) : '0;
                state_next = ST_READ2;
            end
            ST_READ2: begin
                mul_start  = 1'b1;
                mul_mcand  = MCW'(tap_diff);
                mul_mplier = MW'(frac);
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                if (mul_done) begin
                    post_next  = post_val;
                    state_next = ST_GAIN_GO;
                end
            end
            ST_GAIN_GO: begin
                mul_start  = 1'b1;
                mul_mcand  = MCW'(post_reg);
                mul_mplier = MW'(gain_reg);
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                if (mul_done) begin
                    y_next     = y_sat;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hand the beat to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    out_next     = y_reg;
                    m_valid_next = 1'b1;
                    wi_next      = wi_reg + 1'b1;
                    if (wi_reg == AW'(DELAY_DEPTH - 1)) begin
                        wrapped_next = 1'b1;
                    end
                    phase_next = phase_reg + incr_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wi_reg      <= '0;
            wrapped_reg <= 1'b0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wi_reg      <= wi_next;
            wrapped_reg <= wrapped_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
        dry_reg  <= dry_next;
        pos_reg  <= pos_next;
        s0_reg   <= s0_next;
        post_reg <= post_next;
        y_reg    <= y_next;
        out_reg  <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = out_reg;

endmodule

/* src/vcd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module vcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/vcd_sine.sv */
// Sine lookup: folds the table index onto a quarter-wave constant table and
// registers sign and magnitude. Depends on vcd_pkg.
module vcd_sine #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] phase_idx,
    output vcd_pkg::sine_t                      sine
);

    localparam int L  = $clog2(SINE_TABLE_DEPTH);
    localparam int QN = SINE_TABLE_DEPTH / 4;
    localparam int JW = L - 1;

    logic [vcd_pkg::SINE_MAG_W-1:0] qtab [QN+1];
    logic [1:0]                     quad;
    logic [L-3:0]                   rem;
    logic [JW-1:0]                  j;
    vcd_pkg::sine_t                 sine_reg;

    // Quarter-wave table, entry QN is the peak
    for (genvar k = 0; k <= QN; k++) begin : g_tab
        assign qtab[k] = vcd_pkg::sine_quarter(k, 32 - L);
    end

    // Odd quadrants run the quarter wave backwards, the upper half is negative
    assign quad = phase_idx[L-1:L-2];
    assign rem  = phase_idx[L-3:0];
    assign j    = quad[0] ? (JW'(QN) - {1'b0, rem}) : {1'b0, rem};

    always_ff @(posedge aclk) begin
        sine_reg.mag <= qtab[j];
        sine_reg.neg <= quad[1];
    end

    assign sine = sine_reg;

endmodule

/* src/vcd_sermul.sv */
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, LSB first. No dependencies.
module vcd_sermul #(
    parameter int MCAND_W  = 17,
    parameter int MPLIER_W = 18
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [MCAND_W-1:0]         mcand,
    input  logic [MPLIER_W-1:0]               mplier,
    output logic                              done,
    output logic signed [MCAND_W+MPLIER_W:0]  product
);

    localparam int CW = $clog2(MPLIER_W);

    logic signed [MCAND_W:0]   acc_reg;
    logic [MPLIER_W-1:0]       mpl_reg;
    logic signed [MCAND_W-1:0] mcand_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [MCAND_W+1:0] addend;
    logic signed [MCAND_W+1:0] sum;

    // One partial product per cycle; the sum's low bit shifts into the product
    assign addend = mpl_reg[0] ? (MCAND_W+2)'(mcand_reg) : '0;
    assign sum    = (MCAND_W+2)'(acc_reg) + addend;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MPLIER_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg   <= '0;
            mpl_reg   <= mplier;
            mcand_reg <= mcand;
        end else if (busy_reg) begin
            acc_reg <= sum[MCAND_W+1:1];
            mpl_reg <= {sum[0], mpl_reg[MPLIER_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {acc_reg, mpl_reg};

endmodule

/* src/vcd_checker.sv */
// Port-level checker for vibrato_chorus_delay and the bind that attaches it.
// No package dependency; sees only the top level's handshake ports and result sample.
module vcd_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [SAMPLE_WIDTH-1:0] m_out_sample
);

    // Coming out of reset the block is idle with no result pending
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (s_ready && !m_valid))
        else $error("block not idle after reset");

    // One sample in flight: an accepted beat closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sample is in flight");

    // A result only appears while a sample is being worked on
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result beat without a sample in flight");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_sample)))
        else $error("stalled result beat changed");

endmodule

bind vibrato_chorus_delay vcd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_vcd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample)
);
